// File: src/gcb_pkg.sv
// Shared widths, codes and stage payload types for the geofence check pipeline.
`default_nettype none

package gcb_pkg;

  // Input field widths
  localparam int LAT_DEG_W = 7;
  localparam int LON_DEG_W = 8;
  localparam int MIN_W     = 20;

  // Configuration register widths
  localparam int CLAT_W     = 27;
  localparam int CLON_W     = 28;
  localparam int RAD_W      = 27;
  localparam int SHAPE_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;

  // Fixed-point coordinate widths, 1/600000 degree units
  localparam int LAT_W  = 28;  // signed fix latitude
  localparam int LON_W  = 29;  // signed fix longitude
  localparam int DLAT_W = 29;  // signed latitude offset from center
  localparam int DLON_W = 30;  // signed longitude offset from center
  localparam int ALAT_W = 28;  // magnitude of latitude offset
  localparam int ALON_W = 29;  // magnitude of longitude offset

  // Squared distance widths
  localparam int SQ_LAT_W = 2 * ALAT_W;
  localparam int SQ_LON_W = 2 * ALON_W;
  localparam int R_SQ_W   = 2 * RAD_W;
  localparam int SUM_W    = SQ_LON_W + 1;

  // Minute units per degree: one unit is 1/10000 minute
  localparam int UNITS_PER_DEG = 600000;

  // Register stages from input to result, and an in-flight counter width
  localparam int PIPE_DEPTH = 4;
  localparam int CNT_W      = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_LAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_LON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE      = 2'd3;

  // Fence shape codes
  localparam logic [SHAPE_W-1:0] SHAPE_CIRCLE = 2'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_BOX    = 2'd1;

  // Fence configuration
  typedef struct packed {
    logic signed [CLAT_W-1:0] center_lat;
    logic signed [CLON_W-1:0] center_lon;
    logic [RAD_W-1:0]         radius;
    logic [SHAPE_W-1:0]       shape;
  } gcb_cfg_t;

  // Stage 1 payload: signed fix position
  typedef struct packed {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } gcb_pos_t;

  // Stage 2 payload: offset magnitudes
  typedef struct packed {
    logic [ALAT_W-1:0] abs_lat;
    logic [ALON_W-1:0] abs_lon;
  } gcb_delta_t;

  // Stage 3 payload: squares and box test
  typedef struct packed {
    logic [SQ_LAT_W-1:0] sq_lat;
    logic [SQ_LON_W-1:0] sq_lon;
    logic [R_SQ_W-1:0]   r_sq;
    logic                box_ok;
  } gcb_sq_t;

endpackage

`default_nettype wire

// File: src/gcb_if.sv
// Valid/ready channel interfaces for GPS fixes and fence results.
`default_nettype none

interface gcb_fix_if;
  import gcb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [LAT_DEG_W-1:0] lat_degrees;
  logic [MIN_W-1:0]     lat_minutes;
  logic                 lat_south;
  logic [LON_DEG_W-1:0] lon_degrees;
  logic [MIN_W-1:0]     lon_minutes;
  logic                 lon_west;

  modport source (
    output valid, lat_degrees, lat_minutes, lat_south,
    output lon_degrees, lon_minutes, lon_west,
    input  ready
  );

  modport sink (
    input  valid, lat_degrees, lat_minutes, lat_south,
    input  lon_degrees, lon_minutes, lon_west,
    output ready
  );
endinterface

interface gcb_res_if;
  logic valid;
  logic ready;
  logic inside_fence;

  modport source (output valid, inside_fence, input ready);
  modport sink (input valid, inside_fence, output ready);
endinterface

`default_nettype wire

// File: src/gcb_delta.sv
// Stages 1 and 2: fixed-point fix position, then offset magnitudes from the center.
`default_nettype none

module gcb_delta (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  gcb_fix_if.sink                fix,
  input  wire gcb_pkg::gcb_cfg_t cfg_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output gcb_pkg::gcb_delta_t    delta_o
);
  import gcb_pkg::*;

  logic                  s1_valid_q;
  logic                  s1_ready;
  logic                  s2_valid_q;
  logic                  s2_ready;
  logic [LAT_W-2:0]      lat_mag;
  logic [LON_W-2:0]      lon_mag;
  logic signed [LAT_W-1:0] lat_pos;
  logic signed [LON_W-1:0] lon_pos;
  gcb_pos_t              pos_d, pos_q;
  logic signed [DLAT_W-1:0] dlat;
  logic signed [DLON_W-1:0] dlon;
  gcb_delta_t            delta_d, delta_q;

  // Stage ready: slot empty or the next stage takes its contents
  assign s2_ready  = !s2_valid_q || ready_i;
  assign s1_ready  = !s1_valid_q || s2_ready;
  assign fix.ready = s1_ready;

  // Stage 1 logic: degrees * 600000 + minutes, negated for south/west
  always_comb begin
    lat_mag = (LAT_W-1)'(fix.lat_degrees) * (LAT_W-1)'(UNITS_PER_DEG)
            + (LAT_W-1)'(fix.lat_minutes);
    lon_mag = (LON_W-1)'(fix.lon_degrees) * (LON_W-1)'(UNITS_PER_DEG)
            + (LON_W-1)'(fix.lon_minutes);
    lat_pos = $signed({1'b0, lat_mag});
    lon_pos = $signed({1'b0, lon_mag});
    pos_d.lat = fix.lat_south ? -lat_pos : lat_pos;
    pos_d.lon = fix.lon_west  ? -lon_pos : lon_pos;
  end

  // Stage 2 logic: subtract center, take magnitude
  always_comb begin
    dlat = $signed({pos_q.lat[LAT_W-1], pos_q.lat})
         - $signed({{(DLAT_W-CLAT_W){cfg_i.center_lat[CLAT_W-1]}}, cfg_i.center_lat});
    dlon = $signed({pos_q.lon[LON_W-1], pos_q.lon})
         - $signed({{(DLON_W-CLON_W){cfg_i.center_lon[CLON_W-1]}}, cfg_i.center_lon});
    delta_d.abs_lat = dlat[DLAT_W-1] ? ALAT_W'(-dlat) : ALAT_W'(dlat);
    delta_d.abs_lon = dlon[DLON_W-1] ? ALON_W'(-dlon) : ALON_W'(dlon);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= fix.valid;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s1_ready && fix.valid) pos_q   <= pos_d;
    if (s2_ready && s1_valid_q) delta_q <= delta_d;
  end

  assign valid_o = s2_valid_q;
  assign delta_o = delta_q;

endmodule

`default_nettype wire

// File: src/gcb_square.sv
// Stage 3: squares of the offsets and radius, and the box bound test.
`default_nettype none

module gcb_square (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire gcb_pkg::gcb_delta_t delta_i,
  input  wire gcb_pkg::gcb_cfg_t   cfg_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output gcb_pkg::gcb_sq_t         sq_o
);
  import gcb_pkg::*;

  logic    valid_q;
  gcb_sq_t sq_d, sq_q;

  assign ready_o = !valid_q || ready_i;

  // Three parallel multipliers plus the inclusive box compare
  always_comb begin
    sq_d.sq_lat = SQ_LAT_W'(delta_i.abs_lat) * SQ_LAT_W'(delta_i.abs_lat);
    sq_d.sq_lon = SQ_LON_W'(delta_i.abs_lon) * SQ_LON_W'(delta_i.abs_lon);
    sq_d.r_sq   = R_SQ_W'(cfg_i.radius) * R_SQ_W'(cfg_i.radius);
    sq_d.box_ok = (ALON_W'(delta_i.abs_lat) <= ALON_W'(cfg_i.radius))
               && (delta_i.abs_lon <= ALON_W'(cfg_i.radius));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) sq_q <= sq_d;
  end

  assign valid_o = valid_q;
  assign sq_o    = sq_q;

endmodule

`default_nettype wire

// File: src/gcb_decide.sv
// Stage 4: circle sum compare, shape select and the result output register.
`default_nettype none

module gcb_decide (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire gcb_pkg::gcb_sq_t sq_i,
  input  wire gcb_pkg::gcb_cfg_t cfg_i,
  gcb_res_if.source             res
);
  import gcb_pkg::*;

  logic             valid_q;
  logic             inside_d, inside_q;
  logic [SUM_W-1:0] dist_sq;

  assign ready_o = !valid_q || res.ready;

  // Pick the test that matches the fence shape
  always_comb begin
    dist_sq = SUM_W'(sq_i.sq_lat) + SUM_W'(sq_i.sq_lon);
    case (cfg_i.shape)
      SHAPE_CIRCLE: inside_d = (dist_sq <= SUM_W'(sq_i.r_sq));
      SHAPE_BOX:    inside_d = sq_i.box_ok;
      default:      inside_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) inside_q <= inside_d;
  end

  assign res.valid        = valid_q;
  assign res.inside_fence = inside_q;

endmodule

`default_nettype wire

// File: src/geofence_circle_box_check_unit.sv
// Geofence check top level: config registers and the four-stage check pipeline.
//
// Usage:
//   fix_i  - sink channel, one GPS fix per transaction (degrees, minutes in
//            1/10000 minute, south/west flags).
//   res_o  - source channel, one inside_fence flag per fix, in fix order.
//   cfg_*  - write port: cfg_we_i with cfg_idx_i picks center_lat (0),
//            center_lon (1), fence_radius (2) or fence_shape (3); the user must
//            write only while no fix is in flight; the block does not enforce.
// Register stages: position, offset, multiply and compare/select.
// Throughput: one fix per cycle unless res_o stalls; each stage has its own
//   valid bit and passes data on whenever its slot is empty or drains, so
//   bubbles close up.
// Stall: when res_o.ready is low the result holds and the stages behind it
//   fill; fix_i.ready drops only when all four stages hold a fix.
// Reset: rst_ni is asynchronous; it empties the pipeline and clears all
//   fence registers to zero (circle mode, zero radius, center at origin).
`default_nettype none

module geofence_circle_box_check_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  gcb_fix_if.sink                                fix_i,
  gcb_res_if.source                              res_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [gcb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [gcb_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import gcb_pkg::*;

  gcb_cfg_t   cfg_q;
  logic       delta_valid, delta_ready;
  gcb_delta_t delta;
  logic       sq_valid, sq_ready;
  gcb_sq_t    sq;

  // Fence registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_LAT: cfg_q.center_lat <= $signed(cfg_data_i[CLAT_W-1:0]);
        CFG_CENTER_LON: cfg_q.center_lon <= $signed(cfg_data_i[CLON_W-1:0]);
        CFG_RADIUS:     cfg_q.radius     <= cfg_data_i[RAD_W-1:0];
        CFG_SHAPE:      cfg_q.shape      <= cfg_data_i[SHAPE_W-1:0];
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  // Stages 1-2
  gcb_delta u_delta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fix     (fix_i),
    .cfg_i   (cfg_q),
    .valid_o (delta_valid),
    .ready_i (delta_ready),
    .delta_o (delta)
  );

  // Stage 3
  gcb_square u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (delta_valid),
    .ready_o (delta_ready),
    .delta_i (delta),
    .cfg_i   (cfg_q),
    .valid_o (sq_valid),
    .ready_i (sq_ready),
    .sq_o    (sq)
  );

  // Stage 4
  gcb_decide u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .ready_o (sq_ready),
    .sq_i    (sq),
    .cfg_i   (cfg_q),
    .res     (res_o)
  );

endmodule

`default_nettype wire

// File: src/gcb_checker.sv
// Port-level checker for the geofence check unit, with its bind.
`default_nettype none

module gcb_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_i,
  input wire logic                           out_valid_i,
  input wire logic                           out_ready_i,
  input wire logic                           inside_i,
  input wire logic                           cfg_we_i,
  input wire logic [gcb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input wire logic [gcb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gcb_pkg::*;

  logic [CNT_W-1:0]   inflight_q;
  logic [SHAPE_W-1:0] shape_q;

  // Fixes accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + CNT_W'(in_valid_i && in_ready_i)
                              - CNT_W'(out_valid_i && out_ready_i);
    end
  end

  // Shadow of the shape register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= SHAPE_CIRCLE;
    end else if (cfg_we_i && cfg_idx_i == CFG_SHAPE) begin
      shape_q <= cfg_data_i[SHAPE_W-1:0];
    end
  end

  // No result is shown while in reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // An empty output stage means the whole pipeline can take a fix
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with no result waiting");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(inside_i))
    else $error("stalled result changed");

  // Never more fixes in flight than stages, and no result without a fix
  a_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q <= CNT_W'(PIPE_DEPTH)) && (!out_valid_i || inflight_q != '0))
    else $error("in-flight count out of bounds");

  // No fence shape gives outside
  a_no_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && shape_q != SHAPE_CIRCLE && shape_q != SHAPE_BOX |-> !inside_i)
    else $error("inside reported with no fence shape");

endmodule

bind geofence_circle_box_check_unit gcb_checker u_gcb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (fix_i.valid),
  .in_ready_i  (fix_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .inside_i    (res_o.inside_fence),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i)
);

`default_nettype wire
